// File: src/wtfe_pkg.sv
// ============================================================================
// WWVB time frame encoder package
// Shared types, symbol codes, layout constants and the symbol lookup.
// ============================================================================
`default_nettype none

package wtfe_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 60;
    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Depth of the record queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Symbol codes
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_MARK = 2'd2;

    // DST codes as sent at positions 57 and 58
    localparam logic [1:0] DST_OFF    = 2'd0;
    localparam logic [1:0] DST_ENDS   = 2'd1;
    localparam logic [1:0] DST_BEGINS = 2'd2;
    localparam logic [1:0] DST_ON     = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUT1_POSITIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUT1_TENTHS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAP_SECOND   = 2'd2;

    // Encoded frame contents, one record per accepted time item
    typedef struct packed {
        logic [2:0] minute_tens;
        logic [3:0] min_units;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [1:0] doy_hundreds;
        logic [3:0] doy_tens;
        logic [3:0] doy_units;
        logic       dut1_positive;
        logic [3:0] dut1_tenths;
        logic [3:0] yy_tens;
        logic [3:0] year_units;
        logic       leap_year;
        logic       leap_second;
        logic [1:0] dst;
    } t_frame;

    // Record queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [1:0] bit_sym(input logic b);
        return b ? SYM_ONE : SYM_ZERO;
    endfunction

    // Symbol of one frame position
    function automatic logic [1:0] frame_symbol(input t_frame f, input logic [POS_W-1:0] pos);
        logic [1:0] s;
        s = SYM_ZERO;
        unique case (pos)
            6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: s = SYM_MARK;
            6'd1:  s = bit_sym(f.minute_tens[2]);
            6'd2:  s = bit_sym(f.minute_tens[1]);
            6'd3:  s = bit_sym(f.minute_tens[0]);
            6'd5:  s = bit_sym(f.min_units[3]);
            6'd6:  s = bit_sym(f.min_units[2]);
            6'd7:  s = bit_sym(f.min_units[1]);
            6'd8:  s = bit_sym(f.min_units[0]);
            6'd12: s = bit_sym(f.hour_tens[1]);
            6'd13: s = bit_sym(f.hour_tens[0]);
            6'd15: s = bit_sym(f.hour_units[3]);
            6'd16: s = bit_sym(f.hour_units[2]);
            6'd17: s = bit_sym(f.hour_units[1]);
            6'd18: s = bit_sym(f.hour_units[0]);
            6'd22: s = bit_sym(f.doy_hundreds[1]);
            6'd23: s = bit_sym(f.doy_hundreds[0]);
            6'd25: s = bit_sym(f.doy_tens[3]);
            6'd26: s = bit_sym(f.doy_tens[2]);
            6'd27: s = bit_sym(f.doy_tens[1]);
            6'd28: s = bit_sym(f.doy_tens[0]);
            6'd30: s = bit_sym(f.doy_units[3]);
            6'd31: s = bit_sym(f.doy_units[2]);
            6'd32: s = bit_sym(f.doy_units[1]);
            6'd33: s = bit_sym(f.doy_units[0]);
            6'd36: s = bit_sym(f.dut1_positive);
            6'd37: s = bit_sym(!f.dut1_positive);
            6'd38: s = bit_sym(f.dut1_positive);
            6'd40: s = bit_sym(f.dut1_tenths[3]);
            6'd41: s = bit_sym(f.dut1_tenths[2]);
            6'd42: s = bit_sym(f.dut1_tenths[1]);
            6'd43: s = bit_sym(f.dut1_tenths[0]);
            6'd45: s = bit_sym(f.yy_tens[3]);
            6'd46: s = bit_sym(f.yy_tens[2]);
            6'd47: s = bit_sym(f.yy_tens[1]);
            6'd48: s = bit_sym(f.yy_tens[0]);
            6'd50: s = bit_sym(f.year_units[3]);
            6'd51: s = bit_sym(f.year_units[2]);
            6'd52: s = bit_sym(f.year_units[1]);
            6'd53: s = bit_sym(f.year_units[0]);
            6'd55: s = bit_sym(f.leap_year);
            6'd56: s = bit_sym(f.leap_second);
            6'd57: s = bit_sym(f.dst[1]);
            6'd58: s = bit_sym(f.dst[0]);
            default: s = SYM_ZERO;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: src/wtfe_front.sv
// ============================================================================
// WWVB time frame encoder front end
// Two-stage encoder: splits the time fields into BCD digits, derives the
// leap-year flag and the DST code, and pushes one frame record to the queue.
// ============================================================================
`default_nettype none

module wtfe_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // time input channel
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [5:0]           i_minute,
    input  wire logic [4:0]           i_hour,
    input  wire logic [8:0]           i_day_of_year,
    input  wire logic [13:0]          i_full_year,
    input  wire logic [3:0]           i_month,
    input  wire logic [4:0]           i_day_of_month,
    input  wire logic [2:0]           i_day_of_week,
    // configuration
    input  wire logic                 i_dut1_positive,
    input  wire logic [3:0]           i_dut1_tenths,
    input  wire logic                 i_leap_second,
    // record queue write side
    input  wire wtfe_pkg::t_q_status  i_q_status,
    output logic                      o_q_push,
    output wtfe_pkg::t_frame          o_q_rec
);

    // Split a value below 100 into tens and units (reciprocal of 10)
    function automatic logic [7:0] split_tens(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  sub;
        logic [6:0]  units;
        prod  = {8'd0, v} * 15'd205;
        tens  = prod[14:11];
        sub   = {3'd0, tens} * 7'd10;
        units = v - sub;
        return {tens, units[3:0]};
    endfunction

    // Stage 1 registers: raw fields and first quotients
    logic        r_s1_valid;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;
    logic [8:0]  r_doy;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_dom;
    logic [2:0]  r_dow;
    logic [2:0]  r_minute_tens;
    logic [1:0]  r_hour_tens;
    logic [2:0]  r_doy_hund;
    logic [7:0]  r_year_cent;

    logic        s1_ready;
    logic        accept;

    // Stage 1 quotients by reciprocal multiply
    logic [9:0]  min_prod;
    logic [8:0]  hour_prod;
    logic [14:0] doy_prod;
    logic [26:0] year_prod;

    assign min_prod  = {4'd0, i_minute} * 10'd13;
    assign hour_prod = {4'd0, i_hour} * 9'd13;
    assign doy_prod  = {6'd0, i_day_of_year} * 15'd41;
    assign year_prod = {13'd0, i_full_year} * 27'd5243;

    // Advance stage 1 when it is empty or its record moves into the queue
    assign o_q_push = r_s1_valid && !i_q_status.full;
    assign s1_ready = !r_s1_valid || o_q_push;
    assign o_full   = !s1_ready;
    assign accept   = i_push && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_push;
        end
        if (accept) begin
            r_minute      <= i_minute;
            r_hour        <= i_hour;
            r_doy         <= i_day_of_year;
            r_year        <= i_full_year;
            r_month       <= i_month;
            r_dom         <= i_day_of_month;
            r_dow         <= i_day_of_week;
            r_minute_tens <= min_prod[9:7];
            r_hour_tens   <= hour_prod[8:7];
            r_doy_hund    <= doy_prod[14:12];
            r_year_cent   <= year_prod[26:19];
        end
    end

    // Stage 2: remainders and second digit split
    logic [5:0]  min_sub;
    logic [5:0]  min_rem;
    logic [4:0]  hour_sub;
    logic [4:0]  hour_rem;
    logic [8:0]  doy_sub;
    logic [8:0]  doy_rem;
    logic [13:0] year_sub;
    logic [13:0] year_rem;
    logic [7:0]  doy_split;
    logic [7:0]  year_split;
    logic        leap;

    assign min_sub    = {3'd0, r_minute_tens} * 6'd10;
    assign min_rem    = r_minute - min_sub;
    assign hour_sub   = {3'd0, r_hour_tens} * 5'd10;
    assign hour_rem   = r_hour - hour_sub;
    assign doy_sub    = {6'd0, r_doy_hund} * 9'd100;
    assign doy_rem    = r_doy - doy_sub;
    assign year_sub   = {6'd0, r_year_cent} * 14'd100;
    assign year_rem   = r_year - year_sub;
    assign doy_split  = split_tens(doy_rem[6:0]);
    assign year_split = split_tens(year_rem[6:0]);

    // Gregorian rule: century years need the century count divisible by 4
    assign leap = (year_rem[6:0] == 7'd0) ? (r_year_cent[1:0] == 2'd0)
                                          : (r_year[1:0] == 2'd0);

    // DST code from month, day of month and weekday
    logic signed [6:0] sun_before;
    logic [1:0]        dst;

    assign sun_before = $signed({2'b00, r_dom}) - $signed({4'b0000, r_dow});

    always_comb begin
        dst = wtfe_pkg::DST_OFF;
        if (r_month >= 4'd4 && r_month <= 4'd10) begin
            dst = wtfe_pkg::DST_ON;
        end else if (r_month == 4'd3) begin
            if (r_dow == 3'd0 && r_dom >= 5'd8 && r_dom <= 5'd14) begin
                dst = wtfe_pkg::DST_BEGINS;
            end else if (sun_before >= 7'sd8) begin
                dst = wtfe_pkg::DST_ON;
            end
        end else if (r_month == 4'd11) begin
            if (r_dow == 3'd0 && r_dom >= 5'd1 && r_dom <= 5'd7) begin
                dst = wtfe_pkg::DST_ENDS;
            end else if (sun_before <= 7'sd0) begin
                dst = wtfe_pkg::DST_ON;
            end
        end
    end

    // Assemble the record
    always_comb begin
        o_q_rec               = '0;
        o_q_rec.minute_tens   = r_minute_tens;
        o_q_rec.min_units     = min_rem[3:0];
        o_q_rec.hour_tens     = r_hour_tens;
        o_q_rec.hour_units    = hour_rem[3:0];
        o_q_rec.doy_hundreds  = r_doy_hund[1:0];
        o_q_rec.doy_tens      = doy_split[7:4];
        o_q_rec.doy_units     = doy_split[3:0];
        o_q_rec.dut1_positive = i_dut1_positive;
        o_q_rec.dut1_tenths   = i_dut1_tenths;
        o_q_rec.yy_tens       = year_split[7:4];
        o_q_rec.year_units    = year_split[3:0];
        o_q_rec.leap_year     = leap;
        o_q_rec.leap_second   = i_leap_second;
        o_q_rec.dst           = dst;
    end

endmodule

`default_nettype wire

// File: src/wtfe_queue.sv
// ============================================================================
// WWVB time frame encoder record queue
// Small register FIFO of frame records between the encoder and the emitter.
// ============================================================================
`default_nettype none

module wtfe_queue #(
    parameter int unsigned Depth = wtfe_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire wtfe_pkg::t_frame     i_rec,
    input  wire logic                 i_pop,
    output wtfe_pkg::t_frame          o_rec,
    output wtfe_pkg::t_q_status       o_status
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    wtfe_pkg::t_frame r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CntW'(Depth));
    assign o_status.empty = (r_count == '0);
    assign o_rec          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store records
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// File: src/wtfe_back.sv
// ============================================================================
// WWVB time frame encoder emitter
// Walks one frame record through its 60 positions into an output register
// that the receiver drains, one symbol per cycle while the receiver pops.
// ============================================================================
`default_nettype none

module wtfe_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // record queue read side
    input  wire wtfe_pkg::t_q_status  i_q_status,
    input  wire wtfe_pkg::t_frame     i_q_rec,
    output logic                      o_q_pop,
    // symbol output channel
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic [1:0]                o_symbol,
    output logic [wtfe_pkg::POS_W-1:0] o_position,
    output logic                      o_last
);

    wtfe_pkg::t_frame              r_rec;
    logic                          r_busy;
    logic [wtfe_pkg::POS_W-1:0]    r_pos;
    logic                          r_out_valid;
    logic [1:0]                    r_out_sym;
    logic [wtfe_pkg::POS_W-1:0]    r_out_pos;
    logic                          r_out_last;

    logic adv;
    logic fin;
    logic load;

    // Output register moves when empty or being drained
    assign adv     = !r_out_valid || i_pop;
    assign fin     = r_busy && adv && (r_pos == wtfe_pkg::LAST_POS);
    assign load    = !i_q_status.empty && (!r_busy || fin);
    assign o_q_pop = load;

    assign o_empty    = !r_out_valid;
    assign o_symbol   = r_out_sym;
    assign o_position = r_out_pos;
    assign o_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // emit the current position
            if (adv) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_out_sym  <= wtfe_pkg::frame_symbol(r_rec, r_pos);
                    r_out_pos  <= r_pos;
                    r_out_last <= (r_pos == wtfe_pkg::LAST_POS);
                end
            end
            // take the next record, drop to idle after the last symbol, or advance
            if (load) begin
                r_rec  <= i_q_rec;
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
                r_pos  <= '0;
            end else if (r_busy && adv) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/wwvb_time_frame_encoder.sv
// ============================================================================
// WWVB time frame encoder
// Turns one broken-down UTC time into the 60 symbols of a WWVB amplitude frame.
// ============================================================================
// Usage:
//   Time items enter through i_push / o_full; an item is taken at a clock edge
//   with i_push high and o_full low. Symbols leave through o_empty / i_pop:
//   while o_empty is low the oldest symbol is on o_symbol, o_position and
//   o_last, and it is taken at an edge with i_pop high.
//   Each item yields 60 symbols, positions 0 to 59, o_last on position 59.
//   With the emitter idle, an item passes the encoder stage, queue and emitter
//   record register before its first symbol shows. Symbols leave one per cycle
//   while i_pop stays high, set by the emitter's position counter. The encoder
//   and queue hold further items, so input is taken while a frame is still
//   being sent; o_full rises once the queue and encoder stage fill. If the
//   receiver holds i_pop low, the symbol on the ports stays and the emitter
//   waits; the encoder keeps filling the queue until it is full. The user must
//   write configuration (DUT1 sign, DUT1 tenths, leap second warning) via
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; not enforced.
//   Synchronous reset clears the queue, the emitter and configuration to 0.
// ============================================================================
`default_nettype none

module wwvb_time_frame_encoder #(
    parameter int unsigned QueueDepth = wtfe_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [wtfe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [wtfe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // time input
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic [5:0]                         i_minute,
    input  wire logic [4:0]                         i_hour,
    input  wire logic [8:0]                         i_day_of_year,
    input  wire logic [13:0]                        i_full_year,
    input  wire logic [3:0]                         i_month,
    input  wire logic [4:0]                         i_day_of_month,
    input  wire logic [2:0]                         i_day_of_week,
    // symbol output
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [1:0]                              o_symbol,
    output logic [5:0]                              o_position,
    output logic                                    o_last
);

    logic       r_dut1_positive;
    logic [3:0] r_dut1_tenths;
    logic       r_leap_second;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dut1_positive <= 1'b0;
            r_dut1_tenths   <= '0;
            r_leap_second   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wtfe_pkg::CFG_DUT1_POSITIVE: r_dut1_positive <= i_cfg_data[0];
                wtfe_pkg::CFG_DUT1_TENTHS:   r_dut1_tenths   <= i_cfg_data[3:0];
                wtfe_pkg::CFG_LEAP_SECOND:   r_leap_second   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    wtfe_pkg::t_q_status q_status;
    wtfe_pkg::t_frame    front_rec;
    wtfe_pkg::t_frame    queue_rec;
    logic                q_push;
    logic                q_pop;

    wtfe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_minute        (i_minute),
        .i_hour          (i_hour),
        .i_day_of_year   (i_day_of_year),
        .i_full_year     (i_full_year),
        .i_month         (i_month),
        .i_day_of_month  (i_day_of_month),
        .i_day_of_week   (i_day_of_week),
        .i_dut1_positive (r_dut1_positive),
        .i_dut1_tenths   (r_dut1_tenths),
        .i_leap_second   (r_leap_second),
        .i_q_status      (q_status),
        .o_q_push        (q_push),
        .o_q_rec         (front_rec)
    );

    wtfe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_rec    (front_rec),
        .i_pop    (q_pop),
        .o_rec    (queue_rec),
        .o_status (q_status)
    );

    wtfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_rec    (queue_rec),
        .o_q_pop    (q_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_symbol   (o_symbol),
        .o_position (o_position),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

// File: src/wtfe_checker.sv
// ============================================================================
// WWVB time frame encoder checker
// Port-level properties of the symbol stream, bound to the top level.
// ============================================================================
`default_nettype none

module wtfe_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_empty,
    input  wire logic       i_pop,
    input  wire logic [1:0] o_symbol,
    input  wire logic [5:0] o_position,
    input  wire logic       o_last
);

    // Last flag marks exactly the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last == (o_position == wtfe_pkg::LAST_POS)))
        else $error("last flag does not match position 59");

    // Positions within a frame follow each other
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last) |=>
            (o_empty || o_position == $past(o_position) + 6'd1))
        else $error("frame position skipped or repeated");

    // A new frame starts at position zero
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last) |=> (o_empty || o_position == 6'd0))
        else $error("frame did not restart at position 0");

    // Marker positions always carry a marker, nothing else does
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_symbol == wtfe_pkg::SYM_MARK) ==
            (o_position == 6'd0 || o_position == 6'd9 || o_position == 6'd19 ||
             o_position == 6'd29 || o_position == 6'd39 || o_position == 6'd49 ||
             o_position == 6'd59)))
        else $error("marker symbol at wrong position");

    // A stalled symbol holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_symbol) && $stable(o_position)))
        else $error("stalled symbol changed");

endmodule

bind wwvb_time_frame_encoder wtfe_checker u_wtfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_empty    (o_empty),
    .i_pop      (i_pop),
    .o_symbol   (o_symbol),
    .o_position (o_position),
    .o_last     (o_last)
);

`default_nettype wire
